@@ rtl/local_statistics_enhance_defines.svh @@
// ----------------------------------------------------------------------------
// Local statistics enhancement: assertion macros
// Shared concurrent assertion forms used by the enhancement datapath.
// ----------------------------------------------------------------------------
`ifndef LOCAL_STATISTICS_ENHANCE_DEFINES_SVH
`define LOCAL_STATISTICS_ENHANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lse_pkg.sv @@
// ----------------------------------------------------------------------------
// Local statistics enhancement: package
// Widths, register codes, reset values and payload types of the block.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int WIN_PIXELS  = 9;
  localparam int SUM_BITS    = PIXEL_BITS + 4;
  localparam int SQ_BITS     = 2 * PIXEL_BITS;
  localparam int SQSUM_BITS  = SQ_BITS + 4;
  localparam int SPREAD_BITS = 2 * PIXEL_BITS + 7;
  localparam int GAIN_BITS   = 4;
  localparam int PROD_BITS   = PIXEL_BITS + GAIN_BITS;

  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;

  localparam int WIN_CENTRE  = 4;
  localparam int WIN_CURRENT = 7;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = SPREAD_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SUM_LIMIT   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPREAD_LOW  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPREAD_HIGH = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN        = 2'd3;

  localparam logic [SUM_BITS-1:0]    SUM_LIMIT_RESET   = 12'd918;
  localparam logic [SPREAD_BITS-1:0] SPREAD_LOW_RESET  = 23'd0;
  localparam logic [SPREAD_BITS-1:0] SPREAD_HIGH_RESET = 23'd5267025;
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET        = 4'd4;

  localparam int LSE_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] top_pixel;
    logic [PIXEL_BITS-1:0] centre_pixel;
    logic [PIXEL_BITS-1:0] bottom_pixel;
    logic                  row_start;
    logic                  row_end;
    logic                  border_row;
  } lse_in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] out_pixel;
    logic                  last_of_row;
  } lse_out_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]    sum_limit;
    logic [SPREAD_BITS-1:0] spread_low;
    logic [SPREAD_BITS-1:0] spread_high;
    logic [GAIN_BITS-1:0]   gain;
  } lse_cfg_t;

  // Window order: older column 0..2, previous column 3..5, current column 6..8.
  typedef struct packed {
    logic [WIN_PIXELS-1:0][PIXEL_BITS-1:0] win;
    logic                                  win_valid;
    logic                                  win_border;
    logic                                  dir_valid;
    logic                                  dir_last;
  } lse_job_t;

endpackage

@@ rtl/local_statistics_enhance.sv @@
// ----------------------------------------------------------------------------
// Local statistics enhancement, 3x3 window
// The block takes one pixel column (top, centre, bottom) per clock and
// returns the centre row's pixels, each either unchanged or scaled by the
// gain when its 3x3 window is dark, not on a border row, and its spread lies
// within the limits. A column is accepted every cycle while the request queue
// (QUEUE_DEPTH entries) has room and reset is released. A result passes
// through the queue, the statistics stages and the output register. The
// column that ends a row of three or more columns gives two results, which
// leave the single output register in turn, which the queue absorbs. The user
// writes configuration registers over the cfg port only while the block is
// idle; the block does not enforce this. The cfg port is always ready.
// ----------------------------------------------------------------------------
module local_statistics_enhance import lse_pkg::*; #(
  parameter int QUEUE_DEPTH = LSE_QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lse_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lse_out_t                  out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  lse_cfg_t cfg_r;
  lse_job_t push_job;
  lse_job_t pop_job;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sum_limit   <= SUM_LIMIT_RESET;
      cfg_r.spread_low  <= SPREAD_LOW_RESET;
      cfg_r.spread_high <= SPREAD_HIGH_RESET;
      cfg_r.gain        <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SUM_LIMIT: begin
          cfg_r.sum_limit <= cfg_data[SUM_BITS-1:0];
        end
        CFG_SPREAD_LOW: begin
          cfg_r.spread_low <= cfg_data[SPREAD_BITS-1:0];
        end
        CFG_SPREAD_HIGH: begin
          cfg_r.spread_high <= cfg_data[SPREAD_BITS-1:0];
        end
        CFG_GAIN: begin
          cfg_r.gain <= cfg_data[GAIN_BITS-1:0];
        end
      endcase
    end
  end

  lse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  lse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  lse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/lse_front.sv @@
// ----------------------------------------------------------------------------
// Local statistics enhancement: front end
// Accepts pixel columns, tracks the row position and the two held columns,
// and queues one request per column that produces results.
// ----------------------------------------------------------------------------
module lse_front import lse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lse_in_t  in_data,
  input  logic     q_full,
  output logic     q_push,
  output lse_job_t q_job
);

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  logic [2:0][PIXEL_BITS-1:0] cur;
  logic [2:0][PIXEL_BITS-1:0] prev_r;
  logic [2:0][PIXEL_BITS-1:0] older_r;
  logic [1:0]                 seen_r;
  logic [1:0]                 seen_eff;
  logic [1:0]                 seen_nxt;
  logic                       border_r;
  logic                       accept;
  logic                       emit_win;
  logic                       emit_dir;

  assign cur      = {in_data.bottom_pixel, in_data.centre_pixel, in_data.top_pixel};
  assign in_stall = q_full | ~rst_n;
  assign accept   = in_valid & ~in_stall;

  assign seen_eff = in_data.row_start ? SEEN_NONE : seen_r;
  assign emit_win = (seen_eff == SEEN_TWO);
  assign emit_dir = (seen_eff == SEEN_NONE) | in_data.row_end;

  always_comb begin
    if (in_data.row_end) begin
      seen_nxt = SEEN_NONE;
    end else if (seen_eff == SEEN_TWO) begin
      seen_nxt = SEEN_TWO;
    end else begin
      seen_nxt = seen_eff + SEEN_ONE;
    end
  end

  assign q_push           = accept & (emit_win | emit_dir);
  assign q_job.win        = {cur, prev_r, older_r};
  assign q_job.win_valid  = emit_win;
  assign q_job.win_border = border_r;
  assign q_job.dir_valid  = emit_dir;
  assign q_job.dir_last   = in_data.row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      older_r  <= '0;
      seen_r   <= SEEN_NONE;
      border_r <= 1'b0;
    end else if (accept) begin
      prev_r   <= cur;
      older_r  <= prev_r;
      seen_r   <= seen_nxt;
      border_r <= in_data.border_row;
    end
  end

endmodule

@@ rtl/lse_queue.sv @@
// ----------------------------------------------------------------------------
// Local statistics enhancement: request queue
// Small register FIFO that decouples the front end from the statistics
// datapath.
// ----------------------------------------------------------------------------
`include "local_statistics_enhance_defines.svh"

module lse_queue import lse_pkg::*; #(
  parameter int DEPTH = LSE_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lse_job_t push_data,
  output logic     full,
  input  logic     pop,
  output lse_job_t pop_data,
  output logic     empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  lse_job_t            mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == CNT_BITS'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `LSE_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !empty, "queue popped while empty")
  `LSE_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "queue pushed while full")
  `LSE_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "queue count did not advance")

endmodule

@@ rtl/lse_back.sv @@
// ----------------------------------------------------------------------------
// Local statistics enhancement: statistics datapath
// Three-stage pipeline computing the window sum and scaled variance, the
// enhancement decision and gain, followed by the result emitter.
// ----------------------------------------------------------------------------
`include "local_statistics_enhance_defines.svh"

module lse_back import lse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  lse_cfg_t cfg,
  input  logic     q_empty,
  input  lse_job_t q_job,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output lse_out_t out_data
);

  typedef struct packed {
    logic                  win_valid;
    logic                  win_border;
    logic                  dir_valid;
    logic                  dir_last;
    logic [PIXEL_BITS-1:0] centre;
    logic [PIXEL_BITS-1:0] dir_pixel;
  } lse_ctl_t;

  // Stage 1: squares and pixel sum.
  logic                                s1_v_r;
  logic [WIN_PIXELS-1:0][SQ_BITS-1:0]  s1_sq_r;
  logic [SUM_BITS-1:0]                 s1_sum_r;
  lse_ctl_t                            s1_ctl_r;
  logic [WIN_PIXELS-1:0][SQ_BITS-1:0]  sq_nxt;
  logic [SUM_BITS-1:0]                 sum_nxt;

  // Stage 2: sum of squares and squared sum.
  logic                                s2_v_r;
  logic [SQSUM_BITS-1:0]               s2_sqsum_r;
  logic [2*SUM_BITS-1:0]               s2_ss_r;
  logic [SUM_BITS-1:0]                 s2_sum_r;
  lse_ctl_t                            s2_ctl_r;
  logic [SQSUM_BITS-1:0]               sqsum_nxt;

  // Stage 3: decision and emitter.
  logic                                s3_v_r;
  logic                                s3_win_pend_r;
  logic                                s3_dir_pend_r;
  logic [PIXEL_BITS-1:0]               s3_win_pix_r;
  logic [PIXEL_BITS-1:0]               s3_dir_pix_r;
  logic                                s3_dir_last_r;
  logic [SQSUM_BITS+3:0]               nine_sq;
  logic [SPREAD_BITS-1:0]              spread;
  logic [PROD_BITS-1:0]                prod;
  logic [PIXEL_BITS-1:0]               sat_pix;
  logic                                qualify;
  logic [PIXEL_BITS-1:0]               win_pix_nxt;

  logic                                out_valid_r;
  lse_out_t                            out_data_r;
  logic                                out_load;
  logic                                s1_take;
  logic                                s2_take;
  logic                                s3_take;

  assign out_load = s3_v_r & (~out_valid_r | ~out_stall);
  assign s3_take  = ~s3_v_r | (out_load & ~(s3_win_pend_r & s3_dir_pend_r));
  assign s2_take  = ~s2_v_r | s3_take;
  assign s1_take  = ~s1_v_r | s2_take;
  assign q_pop    = ~q_empty & s1_take;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < WIN_PIXELS; i++) begin
      sq_nxt[i] = SQ_BITS'(q_job.win[i]) * SQ_BITS'(q_job.win[i]);
      sum_nxt   = sum_nxt + SUM_BITS'(q_job.win[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_take) begin
      s1_v_r <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_sq_r              <= sq_nxt;
      s1_sum_r             <= sum_nxt;
      s1_ctl_r.win_valid   <= q_job.win_valid;
      s1_ctl_r.win_border  <= q_job.win_border;
      s1_ctl_r.dir_valid   <= q_job.dir_valid;
      s1_ctl_r.dir_last    <= q_job.dir_last;
      s1_ctl_r.centre      <= q_job.win[WIN_CENTRE];
      s1_ctl_r.dir_pixel   <= q_job.win[WIN_CURRENT];
    end
  end

  always_comb begin
    sqsum_nxt = '0;
    for (int i = 0; i < WIN_PIXELS; i++) begin
      sqsum_nxt = sqsum_nxt + SQSUM_BITS'(s1_sq_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_take) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_sqsum_r <= sqsum_nxt;
      s2_ss_r    <= (2*SUM_BITS)'(s1_sum_r) * (2*SUM_BITS)'(s1_sum_r);
      s2_sum_r   <= s1_sum_r;
      s2_ctl_r   <= s1_ctl_r;
    end
  end

  assign nine_sq = {s2_sqsum_r, 3'b000} + (SQSUM_BITS+4)'(s2_sqsum_r);
  assign spread  = SPREAD_BITS'(nine_sq) - SPREAD_BITS'(s2_ss_r);
  assign qualify = ~s2_ctl_r.win_border
                 & (s2_sum_r <= cfg.sum_limit)
                 & (spread >= cfg.spread_low)
                 & (spread <= cfg.spread_high);
  assign prod    = PROD_BITS'(s2_ctl_r.centre) * PROD_BITS'(cfg.gain);
  assign sat_pix = (|prod[PROD_BITS-1:PIXEL_BITS]) ? PIXEL_MAX : prod[PIXEL_BITS-1:0];
  assign win_pix_nxt = qualify ? sat_pix : s2_ctl_r.centre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r        <= 1'b0;
      s3_win_pend_r <= 1'b0;
      s3_dir_pend_r <= 1'b0;
    end else if (s3_take) begin
      s3_v_r        <= s2_v_r;
      s3_win_pend_r <= s2_v_r & s2_ctl_r.win_valid;
      s3_dir_pend_r <= s2_v_r & s2_ctl_r.dir_valid;
    end else if (out_load) begin
      s3_win_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_win_pix_r  <= win_pix_nxt;
      s3_dir_pix_r  <= s2_ctl_r.dir_pixel;
      s3_dir_last_r <= s2_ctl_r.dir_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (s3_win_pend_r) begin
        out_data_r.out_pixel   <= s3_win_pix_r;
        out_data_r.last_of_row <= 1'b0;
      end else begin
        out_data_r.out_pixel   <= s3_dir_pix_r;
        out_data_r.last_of_row <= s3_dir_last_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LSE_ASSERT_IMP(a_emit_has_work, clk, rst_n, s3_v_r, s3_win_pend_r || s3_dir_pend_r, "emitter holds a request with no result")
  `LSE_ASSERT_NXT(a_pair_order, clk, rst_n, out_load && s3_win_pend_r && s3_dir_pend_r, s3_v_r && s3_dir_pend_r && !s3_win_pend_r, "row end result lost after window result")

endmodule

@@ test/local_statistics_enhance_test.sv @@
// ----------------------------------------------------------------------------
// Local statistics enhancement: self-checking testbench
// A short list of pixel columns checks row starts and ends, border rows, a
// restart in the middle of a row and saturation. Rows of random columns follow
// under several sets of limits. Directed columns mostly list their results;
// a built-in 3x3 model predicts the rest. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module local_statistics_enhance_test;
  import lse_pkg::*;

  localparam int PREDICTED     = -1;
  localparam int DIRECTED_ROWS = 24;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_COLUMNS = 180;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SUM_MAX       = 2295;
  localparam int SPREAD_MAX    = 5267025;

  typedef enum int {STYLE_DARK, STYLE_FULL, STYLE_FLAT, STYLE_EXTREME} px_style_t;

  typedef struct {
    logic [PIXEL_BITS-1:0] top;
    logic [PIXEL_BITS-1:0] centre;
    logic [PIXEL_BITS-1:0] bottom;
    bit                    rs;
    bit                    re;
    bit                    br;
    int                    known;
    logic [PIXEL_BITS-1:0] px0;
    bit                    last0;
    logic [PIXEL_BITS-1:0] px1;
    bit                    last1;
  } directed_row_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  lse_in_t                   in_data   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  lse_out_t                  out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  lse_cfg_t              limits;
  logic [PIXEL_BITS-1:0] prev_col [3];
  logic [PIXEL_BITS-1:0] older_col [3];
  logic [1:0]            cols_held;
  logic                  held_border;
  lse_out_t              predicted [2];

  lse_out_t expected_pixels [$];
  int       idle_pct       = 38;
  logic     hold_out       = 1'b0;
  int       hold_count     = 0;
  int       cols_sent      = 0;
  int       pixels_checked = 0;
  int       settings_used  = 0;
  int       mismatches     = 0;
  int       cycle_count    = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // A row one column wide.
    '{8'd18, 8'd165, 8'd52, 1'b1, 1'b1, 1'b0, 1, 8'd165, 1'b1, 8'd0, 1'b0},
    // A bright row: the window sum is too high to count as dark.
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 1, 8'd255, 1'b0, 8'd0, 1'b0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 1, 8'd255, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 2, 8'd255, 1'b0, 8'd0, 1'b1},
    '{8'd10, 8'd20, 8'd30, 1'b1, 1'b0, 1'b0, 1, 8'd20, 1'b0, 8'd0, 1'b0},
    '{8'd40, 8'd50, 8'd60, 1'b0, 1'b0, 1'b0, 0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd70, 8'd80, 8'd90, 1'b0, 1'b0, 1'b0, PREDICTED, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, PREDICTED, 8'd0, 1'b0, 8'd0, 1'b0},
    // A border row, then a flag change that follows the held column.
    '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1, 1, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd100, 8'd0, 1'b0, 1'b0, 1'b1, 0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1, 8'd100, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 2, 8'd0, 1'b0, 8'd0, 1'b1},
    // A new row that starts before the old one ended.
    '{8'd1, 8'd2, 8'd3, 1'b1, 1'b0, 1'b0, 1, 8'd2, 1'b0, 8'd0, 1'b0},
    '{8'd4, 8'd5, 8'd6, 1'b0, 1'b0, 1'b0, 0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd7, 8'd8, 8'd9, 1'b1, 1'b0, 1'b0, 1, 8'd8, 1'b0, 8'd0, 1'b0},
    '{8'd85, 8'd170, 8'd85, 1'b0, 1'b0, 1'b0, 0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd170, 8'd85, 8'd170, 1'b0, 1'b0, 1'b0, PREDICTED, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd3, 8'd4, 8'd5, 1'b0, 1'b1, 1'b0, PREDICTED, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd9, 8'd9, 8'd9, 1'b1, 1'b0, 1'b0, 1, 8'd9, 1'b0, 8'd0, 1'b0},
    '{8'd6, 8'd7, 8'd8, 1'b0, 1'b1, 1'b0, 1, 8'd7, 1'b1, 8'd0, 1'b0},
    // A lone center of 100 in a dark window saturates with gain four.
    '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 1, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd100, 8'd0, 1'b0, 1'b0, 1'b0, 0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 2, 8'd255, 1'b0, 8'd0, 1'b1}
  };

  local_statistics_enhance u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic lse_out_t enhanced_centre(input lse_in_t col);
    logic [PIXEL_BITS-1:0]  win [9];
    logic [SUM_BITS-1:0]    win_sum;
    logic [SQSUM_BITS-1:0]  sq_sum;
    logic [SPREAD_BITS-1:0] spread;
    logic [PROD_BITS-1:0]   prod;
    lse_out_t               res;
    win = '{older_col[0], older_col[1], older_col[2], prev_col[0], prev_col[1],
            prev_col[2], col.top_pixel, col.centre_pixel, col.bottom_pixel};
    win_sum = '0;
    sq_sum  = '0;
    for (int k = 0; k < 9; k++) begin
      win_sum = win_sum + win[k];
      sq_sum  = sq_sum + win[k] * win[k];
    end
    spread = 9 * sq_sum - win_sum * win_sum;
    res.out_pixel   = prev_col[1];
    res.last_of_row = 1'b0;
    if (!held_border && win_sum <= limits.sum_limit && spread >= limits.spread_low &&
        spread <= limits.spread_high) begin
      prod = prev_col[1] * limits.gain;
      res.out_pixel = (prod > PIXEL_MAX) ? PIXEL_MAX : prod[PIXEL_BITS-1:0];
    end
    return res;
  endfunction

  function automatic int predict_column(input lse_in_t col);
    int n;
    n = 0;
    if (col.row_start) cols_held = 2'd0;
    if (cols_held == 2'd0) begin
      predicted[0].out_pixel   = col.centre_pixel;
      predicted[0].last_of_row = col.row_end;
      n = 1;
    end else begin
      if (cols_held == 2'd2) begin
        predicted[0] = enhanced_centre(col);
        n = 1;
      end
      if (col.row_end) begin
        predicted[n].out_pixel   = col.centre_pixel;
        predicted[n].last_of_row = 1'b1;
        n++;
      end
    end
    older_col   = prev_col;
    prev_col    = '{col.top_pixel, col.centre_pixel, col.bottom_pixel};
    held_border = col.border_row;
    if (col.row_end) cols_held = 2'd0;
    else if (cols_held != 2'd2) cols_held = cols_held + 2'd1;
    return n;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(input px_style_t style, input int base);
    case (style)
      STYLE_DARK: return $urandom_range(40);
      STYLE_FLAT: return base + $urandom_range(3);
      STYLE_EXTREME: return ($urandom_range(1) == 0) ? '0 : PIXEL_MAX;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic send_column(input lse_in_t col, input int known,
                             input lse_out_t first, input lse_out_t second);
    int n;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= col;
    do @(posedge clk); while (in_stall);
    cols_sent++;
    n = predict_column(col);
    if (known == PREDICTED) begin
      for (int k = 0; k < n; k++) expected_pixels.push_back(predicted[k]);
    end else begin
      if (known > 0) expected_pixels.push_back(first);
      if (known > 1) expected_pixels.push_back(second);
    end
  endtask

  task automatic send_row();
    int        width;
    int        base;
    px_style_t style;
    bit        border;
    bit        broken;
    lse_in_t   col;
    width  = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    style  = px_style_t'($urandom_range(3));
    base   = $urandom_range(252);
    border = ($urandom_range(99) < 20);
    broken = ($urandom_range(99) < 8);
    for (int c = 0; c < width; c++) begin
      col.top_pixel    = pick_pixel(style, base);
      col.centre_pixel = pick_pixel(style, base);
      col.bottom_pixel = pick_pixel(style, base);
      col.row_start    = (c == 0);
      col.row_end      = (c == width - 1) && !broken;
      col.border_row   = ($urandom_range(99) < 3) ? !border : border;
      send_column(col, PREDICTED, '0, '0);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SUM_LIMIT:   limits.sum_limit   = val[SUM_BITS-1:0];
      CFG_SPREAD_LOW:  limits.spread_low  = val;
      CFG_SPREAD_HIGH: limits.spread_high = val;
      CFG_GAIN:        limits.gain        = val[GAIN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input lse_cfg_t setting);
    write_reg(CFG_SUM_LIMIT, CFG_DATA_BITS'(setting.sum_limit));
    write_reg(CFG_SPREAD_LOW, setting.spread_low);
    write_reg(CFG_SPREAD_HIGH, setting.spread_high);
    write_reg(CFG_GAIN, CFG_DATA_BITS'(setting.gain));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin : check_results
    lse_out_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no request pending, expected none, got pixel %0d last %0b",
                   $time, out_data.out_pixel, out_data.last_of_row);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked++;
          if (out_data.out_pixel !== want.out_pixel) begin
            $display("%0t: out_pixel mismatch, expected %0d, got %0d",
                     $time, want.out_pixel, out_data.out_pixel);
            mismatches++;
          end
          if (out_data.last_of_row !== want.last_of_row) begin
            $display("%0t: last_of_row mismatch, expected %0b, got %0b",
                     $time, want.last_of_row, out_data.last_of_row);
            mismatches++;
          end
        end
      end
      if (hold_out && hold_count < HOLD_CYCLES) begin
        out_stall  <= 1'b1;
        hold_count <= hold_count + 1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
        if (!hold_out) hold_count <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d results still outstanding.", expected_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    lse_in_t  col;
    lse_out_t first;
    lse_out_t second;
    lse_cfg_t setting;
    int       phase_start;
    limits      = '{SUM_LIMIT_RESET, SPREAD_LOW_RESET, SPREAD_HIGH_RESET, GAIN_RESET};
    prev_col    = '{'0, '0, '0};
    older_col   = '{'0, '0, '0};
    cols_held   = 2'd0;
    held_border = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      col                 = '{directed_rows[i].top, directed_rows[i].centre,
                              directed_rows[i].bottom, directed_rows[i].rs,
                              directed_rows[i].re, directed_rows[i].br};
      first.out_pixel     = directed_rows[i].px0;
      first.last_of_row   = directed_rows[i].last0;
      second.out_pixel    = directed_rows[i].px1;
      second.last_of_row  = directed_rows[i].last1;
      send_column(col, directed_rows[i].known, first, second);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p)
        0: setting = '{SUM_LIMIT_RESET, SPREAD_LOW_RESET, SPREAD_HIGH_RESET, GAIN_RESET};
        1: setting = '{'0, '0, '0, '0};
        2: setting = '{SUM_BITS'(SUM_MAX), '0, SPREAD_BITS'(SPREAD_MAX), '1};
        3: setting = '{SUM_BITS'(SUM_MAX), SPREAD_BITS'(SPREAD_MAX),
                       SPREAD_BITS'(SPREAD_MAX), GAIN_BITS'(1)};
        4: begin
          setting.sum_limit   = $urandom_range(1500, 300);
          setting.spread_low  = $urandom_range(200000);
          setting.spread_high = setting.spread_low + $urandom_range(3000000);
          setting.gain        = $urandom_range(15);
        end
        default: begin
          setting.sum_limit   = $urandom_range(SUM_MAX);
          setting.spread_low  = $urandom_range(50000);
          setting.spread_high = $urandom_range(SPREAD_MAX);
          setting.gain        = $urandom_range(15);
        end
      endcase
      set_limits(setting);
      idle_pct = (p == 2) ? 0 : 38;
      hold_out <= (p == 3);
      phase_start = cols_sent;
      while (cols_sent - phase_start < PHASE_COLUMNS) begin
        if ($urandom_range(99) < 10) send_column(lse_in_t'($urandom), PREDICTED, '0, '0);
        else send_row();
      end
      hold_out <= 1'b0;
    end

    drain_results();
    $display("Sent %0d columns and checked %0d result pixels under %0d limit settings,",
             cols_sent, pixels_checked, settings_used);
    $display("with random idling, one idle-free phase and one long output hold.");
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ local_statistics_enhance.f @@
+incdir+rtl
rtl/lse_pkg.sv
rtl/lse_front.sv
rtl/lse_queue.sv
rtl/lse_back.sv
rtl/local_statistics_enhance.sv
test/local_statistics_enhance_test.sv
